// ===== rtl/ehie_pkg.sv =====
// Shared types, constants and the codeword function for the extended Hamming encoder.
package ehie_pkg;

  localparam int MAX_ORDER_DEF   = 5;
  localparam int SLOT_WIDTH_DEF  = 24;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int ORDER_W     = 3;
  localparam int SYMS_W      = 24;
  localparam int SEQ_W       = 29;
  localparam int PAGE_W      = 14;
  localparam int CW_W        = 32;
  localparam int BITIDX_W    = 5;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_CODE_ORDER       = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_PER_PAGE = 1'b1;

  localparam logic [ORDER_W-1:0] RESET_ORDER = 3'd3;
  localparam logic [SYMS_W-1:0]  RESET_SYMS  = 24'd16384;
  localparam logic [PAGE_W-1:0]  PAGE_LIMIT  = 14'd9999;

  localparam logic [31:0] PAR_MASK_16 = 32'hffff0000;
  localparam logic [31:0] PAR_MASK_8  = 32'hff00ff00;
  localparam logic [31:0] PAR_MASK_4  = 32'hf0f0f0f0;
  localparam logic [31:0] PAR_MASK_2  = 32'hcccccccc;
  localparam logic [31:0] PAR_MASK_1  = 32'haaaaaaaa;

  // One codeword on its way from the front to the back.
  typedef struct packed {
    logic [CW_W-1:0]     cw;
    logic [BITIDX_W-1:0] last_bit;
    logic [SEQ_W-1:0]    seq0;
    logic [PAGE_W-1:0]   page;
    logic                fresh;
    logic                over;
  } sym_t;

  // Open a one-bit hole at position pos, moving the upper bits up.
  function automatic logic [31:0] gap_at(logic [31:0] v, logic [4:0] pos);
    logic [31:0] low;
    low = v & ((32'd1 << pos) - 32'd1);
    return ((v ^ low) << 1) | low;
  endfunction

  // m is already clamped to 2..5.
  function automatic logic [CW_W-1:0] encode(logic [31:0] data, logic [ORDER_W-1:0] m);
    logic [31:0] k;
    logic [31:0] w;
    k = (32'd1 << m) - 32'(m) - 32'd1;
    w = (data & ((32'd1 << k) - 32'd1)) << 3;
    if (m >= 3'd3) w = gap_at(w, 5'd4);
    if (m >= 3'd4) w = gap_at(w, 5'd8);
    if (m >= 3'd5) w = gap_at(w, 5'd16);
    if (m >= 3'd5) w = w | (32'(^(w & PAR_MASK_16)) << 16);
    if (m >= 3'd4) w = w | (32'(^(w & PAR_MASK_8)) << 8);
    if (m >= 3'd3) w = w | (32'(^(w & PAR_MASK_4)) << 4);
    w = w | (32'(^(w & PAR_MASK_2)) << 2);
    w = w | (32'(^(w & PAR_MASK_1)) << 1);
    w = w | 32'(^w);
    return w;
  endfunction

endpackage

// ===== rtl/ehie_in_if.sv =====
// Request channel carrying one payload bit.
interface ehie_in_if;
  logic valid;
  logic ready;
  logic payload_bit;

  modport source (output valid, output payload_bit, input ready);
  modport sink   (input valid, input payload_bit, output ready);
endinterface

// ===== rtl/ehie_out_if.sv =====
// Result channel carrying one codeword bit with its slot and page tags.
interface ehie_out_if;
  logic                        valid;
  logic                        ready;
  logic                        channel_bit;
  logic [ehie_pkg::SEQ_W-1:0]  bit_sequence;
  logic [ehie_pkg::PAGE_W-1:0] page_index;
  logic                        page_start;
  logic                        too_many_pages;
  logic                        last_of_symbol;

  modport source (output valid, output channel_bit, output bit_sequence, output page_index,
                  output page_start, output too_many_pages, output last_of_symbol,
                  input ready);
  modport sink   (input valid, input channel_bit, input bit_sequence, input page_index,
                  input page_start, input too_many_pages, input last_of_symbol,
                  output ready);
endinterface

// ===== rtl/ehie_front.sv =====
// Front end: gathers payload bits, encodes full words and assigns slot and page.
module ehie_front #(
  parameter int MAX_ORDER  = ehie_pkg::MAX_ORDER_DEF,
  parameter int SLOT_WIDTH = ehie_pkg::SLOT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          order_clr,
  input  logic [ehie_pkg::ORDER_W-1:0]  code_order,
  input  logic [ehie_pkg::SYMS_W-1:0]   syms,
  input  logic                          q_full,
  output logic                          push,
  output ehie_pkg::sym_t                entry,
  ehie_in_if.sink                       payload
);

  localparam int DATA_W = (1 << MAX_ORDER) - MAX_ORDER - 1;
  localparam int CNT_W  = $clog2(DATA_W + 1);

  logic [DATA_W-1:0]            data_shift;
  logic [CNT_W-1:0]             data_count;
  logic [SLOT_WIDTH-1:0]        symbol_slot;
  logic [ehie_pkg::PAGE_W-1:0]  page_count;

  logic [ehie_pkg::ORDER_W-1:0] m;
  logic [31:0]                  k32;
  logic [31:0]                  len_m1;
  logic [DATA_W-1:0]            data_shift_next;
  logic [CNT_W-1:0]             count_inc;
  logic                         accept;
  logic                         done;
  logic                         page_adv;
  logic [ehie_pkg::PAGE_W-1:0]  page_inc;
  logic [ehie_pkg::PAGE_W-1:0]  page_use;
  logic [SLOT_WIDTH-1:0]        slot_use;
  logic [31:0]                  slot_wide;
  logic                         over;

  always_comb begin
    if (code_order < ehie_pkg::ORDER_W'(2)) begin
      m = ehie_pkg::ORDER_W'(2);
    end else if (code_order > ehie_pkg::ORDER_W'(MAX_ORDER)) begin
      m = ehie_pkg::ORDER_W'(MAX_ORDER);
    end else begin
      m = code_order;
    end
  end

  assign k32    = (32'd1 << m) - 32'(m) - 32'd1;
  assign len_m1 = (32'd1 << m) - 32'd1;

  assign payload.ready   = !q_full;
  assign accept          = payload.valid && payload.ready;
  assign data_shift_next = (data_shift << 1) | DATA_W'(payload.payload_bit);
  assign count_inc       = data_count + CNT_W'(1);
  assign done            = count_inc >= k32[CNT_W-1:0];
  assign push            = accept && done;

  // Page turns when the slot has run past the page size.
  assign page_adv  = 32'(symbol_slot) >= 32'(syms);
  assign page_inc  = page_count + ehie_pkg::PAGE_W'(1);
  assign page_use  = !page_adv ? page_count :
                     (page_inc >= ehie_pkg::PAGE_LIMIT) ? ehie_pkg::PAGE_LIMIT : page_inc;
  assign slot_use  = page_adv ? '0 : symbol_slot;
  assign slot_wide = 32'(slot_use);
  assign over      = page_use >= ehie_pkg::PAGE_LIMIT;

  always_comb begin
    entry.cw       = ehie_pkg::encode(32'(data_shift_next), m);
    entry.last_bit = len_m1[ehie_pkg::BITIDX_W-1:0];
    entry.seq0     = slot_wide[ehie_pkg::SEQ_W-1:0];
    entry.page     = over ? (ehie_pkg::PAGE_LIMIT - ehie_pkg::PAGE_W'(1)) : page_use;
    entry.fresh    = (slot_use == '0) && !over;
    entry.over     = over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_shift  <= '0;
      data_count  <= '0;
      symbol_slot <= '0;
      page_count  <= '0;
    end else begin
      if (order_clr) begin
        data_shift <= '0;
        data_count <= '0;
      end else if (accept) begin
        if (done) begin
          data_shift <= '0;
          data_count <= '0;
        end else begin
          data_shift <= data_shift_next;
          data_count <= count_inc;
        end
      end
      if (push) begin
        symbol_slot <= slot_use + SLOT_WIDTH'(1);
        page_count  <= page_use;
      end
    end
  end

endmodule

// ===== rtl/ehie_queue.sv =====
// Short first-word-fall-through queue of encoded words between front and back.
module ehie_queue #(
  parameter int DEPTH = ehie_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ehie_pkg::sym_t wr_entry,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output ehie_pkg::sym_t rd_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ehie_pkg::sym_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = fill == CNT_W'(DEPTH);
  assign not_empty = fill != '0;
  assign rd_entry  = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ehie_back.sv =====
// Back end: serializes each codeword MSB first and tags every bit.
module ehie_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  ehie_pkg::sym_t              q_entry,
  input  logic [ehie_pkg::SYMS_W-1:0] syms,
  output logic                        pop,
  ehie_out_if.source                  result
);

  logic                          busy;
  logic [ehie_pkg::CW_W-1:0]     cw;
  logic [ehie_pkg::BITIDX_W-1:0] remaining;
  logic [ehie_pkg::SEQ_W-1:0]    seq;
  logic [ehie_pkg::PAGE_W-1:0]   page;
  logic                          fresh;
  logic                          over;

  logic advance;
  logic emit;
  logic last;

  assign advance = !result.valid || result.ready;
  assign emit    = busy && advance;
  assign last    = remaining == '0;
  // Load the next word as the current one sends its final bit.
  assign pop     = q_valid && (!busy || (emit && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (advance) begin
        result.valid <= emit;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.channel_bit    <= cw[ehie_pkg::CW_W-1];
      result.bit_sequence   <= seq;
      result.page_index     <= page;
      result.page_start     <= fresh;
      result.too_many_pages <= over;
      result.last_of_symbol <= last;
    end
    if (pop) begin
      // Left-align so the codeword MSB sits at the top.
      cw        <= q_entry.cw << (ehie_pkg::BITIDX_W'(ehie_pkg::CW_W - 1) - q_entry.last_bit);
      remaining <= q_entry.last_bit;
      seq       <= q_entry.seq0;
      page      <= q_entry.page;
      fresh     <= q_entry.fresh;
      over      <= q_entry.over;
    end else if (emit) begin
      cw        <= cw << 1;
      remaining <= remaining - ehie_pkg::BITIDX_W'(1);
      seq       <= seq + ehie_pkg::SEQ_W'(syms);
      fresh     <= 1'b0;
    end
  end

endmodule

// ===== rtl/extended_hamming_interleaved_encoder_unit.sv =====
// A completed word is written into the queue, then loaded into the back-end shift
// register, and its bits leave through the output register. Throughput: one result bit
// per cycle while the result side is ready, 2^m result bits per word, set by the single-bit
// serializer in the back end. Requests are taken while the queue has room.
// Reset (synchronous, active high) empties the queue and output, clears the gathered
// bits, slot and page, and sets order 3 and 16384 symbols per page.
module extended_hamming_interleaved_encoder_unit #(
  parameter int MAX_ORDER   = ehie_pkg::MAX_ORDER_DEF,
  parameter int SLOT_WIDTH  = ehie_pkg::SLOT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = ehie_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [ehie_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ehie_pkg::CFG_DATA_W-1:0]   cfg_data,
  ehie_in_if.sink                           payload,
  ehie_out_if.source                        result
);

  logic [ehie_pkg::ORDER_W-1:0] code_order;
  logic [ehie_pkg::SYMS_W-1:0]  symbols_per_page;
  logic [ehie_pkg::SYMS_W-1:0]  syms_eff;
  logic                         order_clr;

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  ehie_pkg::sym_t wr_entry;
  ehie_pkg::sym_t rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_order       <= ehie_pkg::RESET_ORDER;
      symbols_per_page <= ehie_pkg::RESET_SYMS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ehie_pkg::REG_CODE_ORDER:       code_order       <= cfg_data[ehie_pkg::ORDER_W-1:0];
        ehie_pkg::REG_SYMBOLS_PER_PAGE: symbols_per_page <= cfg_data;
        default: ;
      endcase
    end
  end

  // An order change drops any partly gathered word.
  assign order_clr = cfg_write && (cfg_index == ehie_pkg::REG_CODE_ORDER);
  assign syms_eff  = (symbols_per_page == '0) ? ehie_pkg::SYMS_W'(1) : symbols_per_page;

  ehie_front #(
    .MAX_ORDER  (MAX_ORDER),
    .SLOT_WIDTH (SLOT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .order_clr  (order_clr),
    .code_order (code_order),
    .syms       (syms_eff),
    .q_full     (q_full),
    .push       (push),
    .entry      (wr_entry),
    .payload    (payload)
  );

  ehie_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rd_entry  (rd_entry)
  );

  ehie_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (rd_entry),
    .syms    (syms_eff),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== bench/ehie_checker.sv =====
// Channel monitor and codeword predictor for the extended Hamming interleaved encoder.
module ehie_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ehie_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ehie_pkg::CFG_DATA_W-1:0]  cfg_data,
  ehie_in_if                               payload,
  ehie_out_if                              result,
  output int                               fail_count,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MIN_ORDER    = 2;
  localparam int MAX_PRINTED  = 40;

  typedef struct packed {
    logic                        cbit;
    logic [ehie_pkg::SEQ_W-1:0]  seq;
    logic [ehie_pkg::PAGE_W-1:0] page;
    logic                        start;
    logic                        over;
    logic                        last;
  } coded_bit_t;

  coded_bit_t coded_bits_q[$];

  logic [ehie_pkg::ORDER_W-1:0]        order_reg;
  logic [ehie_pkg::SYMS_W-1:0]         page_size;
  logic [25:0]                         gathered;
  logic [4:0]                          gathered_n;
  logic [ehie_pkg::SLOT_WIDTH_DEF-1:0] slot;
  logic [ehie_pkg::PAGE_W-1:0]         page;
  int                                  result_n;

  task automatic flag_mismatch(input string what);
    if (fail_count < MAX_PRINTED) $display("[%0t] result %0d: %s", $realtime, result_n, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Data fills the non-power-of-two positions from 3 up, lowest data bit first;
  // each parity bit p covers the positions with bit p set, bit 0 covers all.
  function automatic logic [31:0] hamming_word(logic [25:0] data, int m);
    logic [31:0] w;
    int len;
    int d;
    w = '0;
    len = 1 << m;
    d = 0;
    for (int pos = 3; pos < len; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        w[pos] = data[d];
        d++;
      end
    end
    for (int p = 1; p < len; p = p << 1) begin
      for (int pos = 3; pos < len; pos++) begin
        if ((pos & p) != 0 && (pos & (pos - 1)) != 0) w[p] = w[p] ^ w[pos];
      end
    end
    w[0] = ^w;
    return w;
  endfunction

  task automatic take_payload(input logic b);
    int m;
    int len;
    int k;
    logic [31:0] word;
    logic [ehie_pkg::SYMS_W-1:0] per_page;
    logic [63:0] seq_full;
    logic over;
    logic fresh;
    coded_bit_t e;
    m = int'(order_reg);
    if (m < MIN_ORDER) m = MIN_ORDER;
    if (m > ehie_pkg::MAX_ORDER_DEF) m = ehie_pkg::MAX_ORDER_DEF;
    len = 1 << m;
    k = len - m - 1;
    gathered = {gathered[24:0], b};
    if (gathered_n < 5'd31) gathered_n++;
    if (int'(gathered_n) < k) return;

    word = hamming_word(gathered, m);
    gathered = '0;
    gathered_n = '0;

    per_page = (page_size == '0) ? ehie_pkg::SYMS_W'(1) : page_size;
    // advance the page once the slots run out; the limit mark sticks
    if (ehie_pkg::SYMS_W'(slot) >= per_page) begin
      if (int'(page) + 1 >= int'(ehie_pkg::PAGE_LIMIT)) page = ehie_pkg::PAGE_LIMIT;
      else page = page + ehie_pkg::PAGE_W'(1);
      slot = '0;
    end
    over = (page >= ehie_pkg::PAGE_LIMIT);
    fresh = (slot == '0) && !over;

    for (int j = 0; j < len; j++) begin
      seq_full = 64'(slot) + 64'(j) * 64'(per_page);
      e.cbit  = word[len - 1 - j];
      e.seq   = seq_full[ehie_pkg::SEQ_W-1:0];
      e.page  = over ? ehie_pkg::PAGE_LIMIT - ehie_pkg::PAGE_W'(1) : page;
      e.start = fresh && (j == 0);
      e.over  = over;
      e.last  = (j == len - 1);
      coded_bits_q.push_back(e);
    end
    slot = slot + ehie_pkg::SLOT_WIDTH_DEF'(1);
  endtask

  always @(posedge clk) begin : watch
    coded_bit_t want;
    if (rst) begin
      order_reg  = ehie_pkg::RESET_ORDER;
      page_size  = ehie_pkg::RESET_SYMS;
      gathered   = '0;
      gathered_n = '0;
      slot       = '0;
      page       = '0;
      result_n   = 0;
      coded_bits_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == ehie_pkg::REG_CODE_ORDER) begin
          // a new order drops the partly gathered word
          order_reg  = cfg_data[ehie_pkg::ORDER_W-1:0];
          gathered   = '0;
          gathered_n = '0;
        end else if (cfg_index == ehie_pkg::REG_SYMBOLS_PER_PAGE) begin
          page_size = cfg_data[ehie_pkg::SYMS_W-1:0];
        end
      end
      if (payload.valid === 1'b1 && payload.ready === 1'b1) take_payload(payload.payload_bit);
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        if (coded_bits_q.size() == 0) begin
          flag_mismatch("result with nothing expected");
        end else begin
          want = coded_bits_q.pop_front();
          check_field("channel_bit", 32'(result.channel_bit), 32'(want.cbit));
          check_field("bit_sequence", 32'(result.bit_sequence), 32'(want.seq));
          check_field("page_index", 32'(result.page_index), 32'(want.page));
          check_field("page_start", 32'(result.page_start), 32'(want.start));
          check_field("too_many_pages", 32'(result.too_many_pages), 32'(want.over));
          check_field("last_of_symbol", 32'(result.last_of_symbol), 32'(want.last));
        end
        result_n++;
      end
    end
    pending = coded_bits_q.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top-level bench: clock, reset, register writes, payload requests and the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_ITEMS  = 310;
  localparam int CALM_TAIL     = 60;
  localparam int PAGE_RUN      = 20;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_write;
  logic [ehie_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ehie_pkg::CFG_DATA_W-1:0]  cfg_data;
  int                               fail_count;
  int                               pending;
  int                               snd_odds;
  int                               rcv_odds;
  bit                               hold_req;
  int                               cycles;
  int                               sent;

  ehie_in_if  payload_ch ();
  ehie_out_if result_ch ();

  extended_hamming_interleaved_encoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .payload   (payload_ch),
    .result    (result_ch)
  );

  ehie_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .payload    (payload_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("extended_hamming_interleaved_encoder_unit regression: fail");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    result_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_req && !held) begin
        result_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
      end else if (rcv_odds != 0 && $urandom_range(0, rcv_odds - 1) == 0) begin
        result_ch.ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        result_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic write_reg(input logic [ehie_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ehie_pkg::CFG_DATA_W-1:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Leave valid high after acceptance so back-to-back requests need no drop.
  task automatic send_bit(input logic b);
    if (snd_odds != 0 && $urandom_range(0, snd_odds - 1) == 0) begin
      payload_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    payload_ch.valid       = 1'b1;
    payload_ch.payload_bit = b;
    do @(posedge clk); while (payload_ch.ready !== 1'b1);
    @(negedge clk);
    sent++;
  endtask

  // Wait for every expected bit, then let the bench idle before the next step.
  task automatic settle();
    payload_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [ehie_pkg::CFG_DATA_W-1:0] pick_page_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ehie_pkg::CFG_DATA_W'(1);
      2:       return ehie_pkg::CFG_DATA_W'(2);
      3:       return '1;
      4:       return ehie_pkg::CFG_DATA_W'($urandom());
      default: return ehie_pkg::CFG_DATA_W'($urandom_range(1, 20));
    endcase
  endfunction

  task automatic random_run(input int n_bits);
    int pattern;
    pattern = $urandom_range(0, 5);
    for (int i = 0; i < n_bits; i++) begin
      case (pattern)
        0:       send_bit(1'b0);
        1:       send_bit(1'b1);
        default: send_bit(1'($urandom()));
      endcase
    end
  endtask

  initial begin
    int phase;
    int order_pick;
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_index              = ehie_pkg::REG_CODE_ORDER;
    cfg_data               = '0;
    payload_ch.valid       = 1'b0;
    payload_ch.payload_bit = 1'b0;
    snd_odds               = 4;
    rcv_odds               = 5;
    hold_req               = 1'b0;
    sent                   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset order and page size
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b1);
    settle();
    // zero page size acts as one slot per page
    write_reg(ehie_pkg::REG_SYMBOLS_PER_PAGE, '0);
    repeat (4) send_bit(1'b0);
    repeat (4) send_bit(1'b1);
    settle();
    // order below range clamps to two
    write_reg(ehie_pkg::REG_CODE_ORDER, ehie_pkg::CFG_DATA_W'(1));
    send_bit(1'b1);
    send_bit(1'b0);
    settle();
    // drop a partly gathered word on an order change
    write_reg(ehie_pkg::REG_CODE_ORDER, ehie_pkg::CFG_DATA_W'(4));
    repeat (5) send_bit(1'b1);
    settle();
    write_reg(ehie_pkg::REG_CODE_ORDER, ehie_pkg::CFG_DATA_W'(2));
    send_bit(1'b1);
    send_bit(1'b1);
    settle();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      order_pick = (phase < 8) ? phase : $urandom_range(0, 7);
      if (phase < 8 || $urandom_range(0, 2) != 0)
        write_reg(ehie_pkg::REG_CODE_ORDER,
                  {ehie_pkg::CFG_DATA_W'($urandom()) << ehie_pkg::ORDER_W} |
                  ehie_pkg::CFG_DATA_W'(order_pick));
      if (phase == 0) write_reg(ehie_pkg::REG_SYMBOLS_PER_PAGE, '1);
      else if ($urandom_range(0, 1) == 0)
        write_reg(ehie_pkg::REG_SYMBOLS_PER_PAGE, pick_page_size());
      if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
        snd_odds = 0;
        rcv_odds = 0;
      end else begin
        snd_odds = $urandom_range(0, 2) * 3;
        rcv_odds = $urandom_range(0, 2) * 3;
      end
      // stall the result side at order two so the queue fills and stops requests
      if (phase == 2) hold_req = 1'b1;
      random_run($urandom_range(8, 40));
      settle();
      phase++;
    end

    // one slot per page at order two: every word opens a new page
    snd_odds = 0;
    rcv_odds = 0;
    write_reg(ehie_pkg::REG_CODE_ORDER, ehie_pkg::CFG_DATA_W'(2));
    write_reg(ehie_pkg::REG_SYMBOLS_PER_PAGE, ehie_pkg::CFG_DATA_W'(1));
    random_run(PAGE_RUN);
    settle();
    write_reg(ehie_pkg::REG_SYMBOLS_PER_PAGE, ehie_pkg::CFG_DATA_W'(3));
    random_run(20);
    settle();

    if (fail_count == 0) begin
      $display("extended_hamming_interleaved_encoder_unit regression: pass");
    end else begin
      $display("extended_hamming_interleaved_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule
